// ===== rtl/rrt_pkg.sv =====
// Shared types, constants and codes of the relay route table.
package rrt_pkg;

  // Table geometry
  localparam int ROUTE_SLOTS = 64;
  localparam int IFACE_SLOTS = 4;
  localparam int IDX_W       = $clog2(ROUTE_SLOTS);
  localparam int CNT_W       = $clog2(ROUTE_SLOTS + 1);
  localparam int STEP_W      = CNT_W + 1;

  // Stream widths
  localparam int IN_DATA_W   = 432;
  localparam int IN_USER_W   = 4;
  localparam int OUT_DATA_W  = 296;
  localparam int OUT_USER_W  = 5;

  // Request types
  localparam logic [1:0] REQ_LOOKUP  = 2'd0;
  localparam logic [1:0] REQ_INSTALL = 2'd1;
  localparam logic [1:0] REQ_REMOVE  = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOROUTE = 2'd1;
  localparam logic [1:0] STAT_UNKNOWN = 2'd2;
  localparam logic [1:0] STAT_FULL    = 2'd3;

  // Route kinds
  localparam logic [1:0] KIND_NONTEMP = 2'd0;
  localparam logic [1:0] KIND_TEMP    = 2'd1;
  localparam logic [1:0] KIND_DELEG   = 2'd2;
  localparam logic [1:0] KIND_EXCL    = 2'd3;

  // Configuration register indexes
  localparam logic CFG_IDS   = 1'b0;
  localparam logic CFG_FLAGS = 1'b1;

  localparam logic [7:0] MAX_LEN  = 8'd128;
  localparam int         FLAG_EXCL = 3;

  typedef struct packed {
    logic [63:0] net_hi;
    logic [63:0] net_lo;
    logic [63:0] hop_hi;
    logic [63:0] hop_lo;
    logic [15:0] iface;
    logic [15:0] port;
    logic [7:0]  len;
    logic [1:0]  kind;
    logic        bh;
  } route_t;

  // Wave that runs down the chain during a scan
  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] cnt;
    route_t           best;
  } token_t;

  // Request held for the whole item, broadcast to every cell
  typedef struct packed {
    route_t      main;
    logic [63:0] excl_hi;
    logic [63:0] excl_lo;
    logic [7:0]  excl_len;
    logic        has_excl;
  } req_t;

  // Per-cycle command to the cells
  typedef struct packed {
    logic             commit;
    logic             compact;
    logic             append;
    logic             add_main;
    logic             add_excl;
    logic [CNT_W-1:0] idx_main;
    logic [CNT_W-1:0] idx_excl;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_COMPACT,
    ST_APPEND,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/rrt_cell.sv =====
// One route slot of the chain: holds a route, scans, compacts and appends.
module rrt_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [rrt_pkg::IDX_W-1:0]     cell_idx,
  input  rrt_pkg::cell_ctl_t            ctl,
  input  rrt_pkg::req_t                 req,
  input  rrt_pkg::token_t               tok_in,
  output rrt_pkg::token_t               tok_out,
  input  logic                          left_valid,
  input  logic                          right_valid,
  input  rrt_pkg::route_t               right_route,
  output logic                          valid,
  output rrt_pkg::route_t               route
);

  logic            kill;
  logic            kill_next;
  logic [63:0]     mask_hi;
  logic [63:0]     mask_lo;
  logic            hit;
  logic            key_main;
  logic            key_excl;
  logic            better;
  logic [rrt_pkg::CNT_W-1:0] my_idx;
  rrt_pkg::route_t excl_route;
  rrt_pkg::token_t tok_next;

  assign my_idx = {1'b0, cell_idx};

  // Build the prefix mask from the stored length
  always_comb begin
    for (int j = 0; j < 64; j++) begin
      mask_hi[j] = (route.len > 8'(63 - j));
      mask_lo[j] = (route.len > 8'(127 - j));
    end
  end

  // Containment and key matches against the broadcast request
  assign hit = (((req.main.net_hi ^ route.net_hi) & mask_hi) == 64'd0) &&
               (((req.main.net_lo ^ route.net_lo) & mask_lo) == 64'd0) &&
               (route.len <= rrt_pkg::MAX_LEN);
  assign key_main = (route.iface == req.main.iface) && (route.len == req.main.len) &&
                    (route.kind == req.main.kind) && (route.net_hi == req.main.net_hi) &&
                    (route.net_lo == req.main.net_lo);
  assign key_excl = req.has_excl && (route.iface == req.main.iface) &&
                    (route.len == req.excl_len) && (route.kind == rrt_pkg::KIND_EXCL) &&
                    (route.net_hi == req.excl_hi) && (route.net_lo == req.excl_lo);
  assign kill_next = valid && (key_main || key_excl);
  assign better = valid && hit && (!tok_in.found || route.len > tok_in.best.len);

  // Advance the scan wave by one cell
  always_comb begin
    tok_next = tok_in;
    tok_next.cnt = tok_in.cnt + rrt_pkg::CNT_W'(valid && !kill_next);
    if (better) begin
      tok_next.found = 1'b1;
      tok_next.best  = route;
    end
  end

  // Blackhole route for an excluded prefix
  always_comb begin
    excl_route        = req.main;
    excl_route.net_hi = req.excl_hi;
    excl_route.net_lo = req.excl_lo;
    excl_route.hop_hi = 64'd0;
    excl_route.hop_lo = 64'd0;
    excl_route.len    = req.excl_len;
    excl_route.kind   = rrt_pkg::KIND_EXCL;
    excl_route.bh     = 1'b1;
  end

  // Scan registers
  always_ff @(posedge clk) begin
    tok_out <= tok_next;
    kill    <= kill_next;
  end

  // Slot contents: drop killed routes, shift left into holes, append
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.commit) begin
      if (kill) valid <= 1'b0;
    end else if (ctl.compact) begin
      if (!valid && right_valid) begin
        valid <= 1'b1;
        route <= right_route;
      end else if (valid && !left_valid) begin
        valid <= 1'b0;
      end
    end else if (ctl.append) begin
      if (ctl.add_main && my_idx == ctl.idx_main) begin
        valid <= 1'b1;
        route <= req.main;
      end else if (ctl.add_excl && my_idx == ctl.idx_excl) begin
        valid <= 1'b1;
        route <= excl_route;
      end
    end
  end

endmodule

// ===== rtl/rrt_ctrl.sv =====
// Sequencer of the route table: item intake, scan, commit, compaction, result.
module rrt_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [rrt_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic [rrt_pkg::IN_USER_W-1:0]     s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [rrt_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [rrt_pkg::OUT_USER_W-1:0]    m_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [63:0]                       cfg_data,
  input  rrt_pkg::token_t                   tok_last,
  output rrt_pkg::req_t                     req,
  output rrt_pkg::cell_ctl_t                ctl
);

  localparam logic [rrt_pkg::STEP_W-1:0] SCAN_END =
    rrt_pkg::STEP_W'(rrt_pkg::ROUTE_SLOTS - 1);
  localparam logic [rrt_pkg::STEP_W-1:0] COMPACT_END =
    rrt_pkg::STEP_W'(2 * rrt_pkg::ROUTE_SLOTS - 1);
  localparam logic [rrt_pkg::STEP_W-1:0] SLOTS_W =
    rrt_pkg::STEP_W'(rrt_pkg::ROUTE_SLOTS);

  rrt_pkg::state_t state, state_next;
  logic [63:0] ids;
  logic [15:0] flags;
  logic [rrt_pkg::STEP_W-1:0] step;
  logic        is_lookup, add_main, add_excl;
  logic [1:0]  res_status;
  rrt_pkg::route_t res_route;
  logic [rrt_pkg::CNT_W-1:0] surv_cnt;

  logic        accept;
  logic [1:0]  in_rt, in_kind, in_mk;
  logic [15:0] in_iface;
  logic [7:0]  in_elen;
  logic        in_lookup, iface_ok, in_has_excl;
  logic [3:0]  iface_flags;
  logic        overfull;
  logic [rrt_pkg::CNT_W-1:0] cnt_plus;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign in_rt     = s_tuser[1:0];
  assign in_kind   = s_tuser[3:2];
  assign in_iface  = s_tdata[15:0];
  assign in_elen   = s_tdata[431:424];
  assign in_lookup = (in_rt == rrt_pkg::REQ_LOOKUP) || (in_rt == 2'd3);
  assign in_has_excl = (in_elen <= rrt_pkg::MAX_LEN);
  assign in_mk = (in_kind == rrt_pkg::KIND_NONTEMP) ? rrt_pkg::KIND_NONTEMP :
                 (in_kind == rrt_pkg::KIND_TEMP) ? rrt_pkg::KIND_TEMP : rrt_pkg::KIND_DELEG;

  // Find the first interface slot with this id
  always_comb begin
    iface_ok    = 1'b0;
    iface_flags = 4'd0;
    for (int i = rrt_pkg::IFACE_SLOTS - 1; i >= 0; i--) begin
      if (ids[16*i +: 16] != 16'd0 && ids[16*i +: 16] == in_iface) begin
        iface_ok    = 1'b1;
        iface_flags = flags[4*i +: 4];
      end
    end
  end

  // Survivors plus appends must fit in the table
  assign cnt_plus = tok_last.cnt + rrt_pkg::CNT_W'(add_main);
  assign overfull = ({1'b0, cnt_plus} + rrt_pkg::STEP_W'(add_excl)) > SLOTS_W;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      rrt_pkg::ST_IDLE: begin
        if (accept) begin
          if (!in_lookup && !iface_ok) state_next = rrt_pkg::ST_DONE;
          else state_next = rrt_pkg::ST_SCAN;
        end
      end
      rrt_pkg::ST_SCAN: begin
        if (step == SCAN_END) state_next = rrt_pkg::ST_DECIDE;
      end
      rrt_pkg::ST_DECIDE: begin
        if (is_lookup || overfull) state_next = rrt_pkg::ST_DONE;
        else state_next = rrt_pkg::ST_COMPACT;
      end
      rrt_pkg::ST_COMPACT: begin
        if (step == COMPACT_END) state_next = rrt_pkg::ST_APPEND;
      end
      rrt_pkg::ST_APPEND: state_next = rrt_pkg::ST_DONE;
      rrt_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) state_next = rrt_pkg::ST_IDLE;
      end
      default: state_next = rrt_pkg::ST_IDLE;
    endcase
  end

  // Outputs toward the cells and the input side
  always_comb begin
    s_tready     = 1'b0;
    ctl          = '0;
    ctl.add_main = add_main;
    ctl.add_excl = add_excl;
    ctl.idx_main = surv_cnt;
    ctl.idx_excl = surv_cnt + rrt_pkg::CNT_W'(add_main);
    case (state)
      rrt_pkg::ST_IDLE:    s_tready    = 1'b1;
      rrt_pkg::ST_DECIDE:  ctl.commit  = !is_lookup && !overfull;
      rrt_pkg::ST_COMPACT: ctl.compact = 1'b1;
      rrt_pkg::ST_APPEND:  ctl.append  = 1'b1;
      default: ;
    endcase
  end

  // State, configuration and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rrt_pkg::ST_IDLE;
      ids      <= 64'd0;
      flags    <= 16'd0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rrt_pkg::CFG_IDS) ids <= cfg_data;
        else flags <= cfg_data[15:0];
      end
      if (state == rrt_pkg::ST_DONE && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // Step counter, request and result registers
  always_ff @(posedge clk) begin
    if (state == rrt_pkg::ST_SCAN || state == rrt_pkg::ST_COMPACT) step <= step + 1'b1;
    else if (state == rrt_pkg::ST_DECIDE) step <= SLOTS_W;
    else step <= '0;

    // Hold the survivor count; the wave skews while the chain compacts
    if (state == rrt_pkg::ST_DECIDE) surv_cnt <= tok_last.cnt;

    if (accept) begin
      req.main.iface  <= in_iface;
      req.main.port   <= s_tdata[31:16];
      req.main.net_hi <= s_tdata[95:32];
      req.main.net_lo <= s_tdata[159:96];
      req.main.len    <= s_tdata[167:160];
      req.main.hop_hi <= s_tdata[231:168];
      req.main.hop_lo <= s_tdata[295:232];
      req.main.kind   <= in_mk;
      req.main.bh     <= 1'b0;
      req.excl_hi     <= s_tdata[359:296];
      req.excl_lo     <= s_tdata[423:360];
      req.excl_len    <= in_elen;
      req.has_excl    <= in_has_excl;
      is_lookup       <= in_lookup;
      add_main        <= (in_rt == rrt_pkg::REQ_INSTALL) && iface_flags[in_mk];
      add_excl        <= (in_rt == rrt_pkg::REQ_INSTALL) && in_has_excl &&
                         iface_flags[rrt_pkg::FLAG_EXCL];
      res_status      <= rrt_pkg::STAT_UNKNOWN;
      res_route       <= '0;
    end else if (state == rrt_pkg::ST_DECIDE) begin
      if (is_lookup) begin
        res_status <= tok_last.found ? rrt_pkg::STAT_OK : rrt_pkg::STAT_NOROUTE;
        res_route  <= tok_last.found ? tok_last.best : '0;
      end else begin
        res_status <= overfull ? rrt_pkg::STAT_FULL : rrt_pkg::STAT_OK;
        res_route  <= '0;
      end
    end

    if (state == rrt_pkg::ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {res_route.port, res_route.iface, res_route.hop_lo, res_route.hop_hi,
                  res_route.len, res_route.net_lo, res_route.net_hi};
      m_tuser <= {res_route.bh, res_route.kind, res_status};
    end
  end

endmodule

// ===== rtl/relay_route_table_lpm.sv =====
// Top level of the relay route table: controller and the chain of route cells.
//
// Usage: items enter on the s_ stream (s_tuser = request type and lease kind,
// s_tdata = lease or lookup fields) and every item yields exactly one result on
// the m_ stream (m_tuser = status, route kind, blackhole; m_tdata = route).
// Configuration writes (index 0 interface ids, index 1 interface flags) use the
// cfg_ channel, which is always ready; write only while the block is idle.
// One item is processed at a time. A lookup runs one wave down the chain of
// ROUTE_SLOTS cells, one cell per cycle, before the result is offered. An
// install or remove adds an order-keeping compaction of the chain and an
// append step. A mutation for an unknown interface answers without a scan,
// one that overfills right after the scan. The next item can be taken from
// the cycle after the result is loaded.
// The result sits in an output register; if the receiver stalls, the next item
// is still taken and processed and waits only at its own result.
// Reset clears the configuration, empties the table and drops any result.
module relay_route_table_lpm (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // iface, port_ordinal, network_hi, network_lo, prefix_len, hop_hi, hop_lo,
  // excl_hi, excl_lo, excl_len
  input  logic [rrt_pkg::IN_DATA_W-1:0]  s_tdata,
  // req_type, lease_kind
  input  logic [rrt_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // route_net_hi, route_net_lo, route_len, route_hop_hi, route_hop_lo,
  // route_iface, route_port
  output logic [rrt_pkg::OUT_DATA_W-1:0] m_tdata,
  // status, route_kind, route_blackhole
  output logic [rrt_pkg::OUT_USER_W-1:0] m_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [63:0]                    cfg_data
);

  rrt_pkg::req_t      req;
  rrt_pkg::cell_ctl_t ctl;
  rrt_pkg::token_t    tok   [rrt_pkg::ROUTE_SLOTS];
  rrt_pkg::token_t    tok_in[rrt_pkg::ROUTE_SLOTS];
  logic               cvalid[rrt_pkg::ROUTE_SLOTS];
  rrt_pkg::route_t    croute[rrt_pkg::ROUTE_SLOTS];

  rrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tok_last  (tok[rrt_pkg::ROUTE_SLOTS-1]),
    .req       (req),
    .ctl       (ctl)
  );

  // Chain of cells; the wave starts empty at cell 0
  for (genvar i = 0; i < rrt_pkg::ROUTE_SLOTS; i++) begin : g_cell
    logic            lv, rv;
    rrt_pkg::route_t rr;
    if (i == 0) begin : g_head
      assign tok_in[i] = '0;
      assign lv = 1'b1;
    end else begin : g_body
      assign tok_in[i] = tok[i-1];
      assign lv = cvalid[i-1];
    end
    if (i == rrt_pkg::ROUTE_SLOTS - 1) begin : g_tail
      assign rv = 1'b0;
      assign rr = '0;
    end else begin : g_next
      assign rv = cvalid[i+1];
      assign rr = croute[i+1];
    end
    rrt_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cell_idx    (rrt_pkg::IDX_W'(i)),
      .ctl         (ctl),
      .req         (req),
      .tok_in      (tok_in[i]),
      .tok_out     (tok[i]),
      .left_valid  (lv),
      .right_valid (rv),
      .right_route (rr),
      .valid       (cvalid[i]),
      .route       (croute[i])
    );
  end

endmodule
